// ===== rtl/led_strip_frame_encoder_defines.svh =====
// Assertion macros shared by the RTL of the LED strip frame encoder.
// Each check is clocked on the rising edge and held off while reset is low.
`ifndef LED_STRIP_FRAME_ENCODER_DEFINES_SVH
`define LED_STRIP_FRAME_ENCODER_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/lsfe_pkg.sv =====
`timescale 1ns / 1ps

package lsfe_pkg;

	localparam int MAX_PIXELS    = 16;
	localparam int BITS_PER_BYTE = 8;
	localparam int CHANNEL_COUNT = 2;

	localparam int MAX_BPP     = 4;
	localparam int STORE_DEPTH = MAX_PIXELS * MAX_BPP;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	// Wide enough to hold the byte count of a full store.
	localparam int USED_W      = STORE_AW + 1;
	localparam int BIT_W       = $clog2(BITS_PER_BYTE);
	localparam int IDX_WIDE_W  = 6 + BIT_W + 3;

	// Field widths.
	localparam int KIND_W     = 2;
	localparam int PIXEL_W    = 4;
	localparam int LEVEL_W    = 8;
	localparam int POS_W      = 6;
	localparam int INDEX_W    = 10;
	localparam int DUTY_W     = 16;
	localparam int PCOUNT_W   = 5;
	localparam int BPP_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_SET_PIXEL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SET_ALL   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RENDER    = 2'd2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_SLOT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_HIGH       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LOW        = 3'd4;

	localparam logic [BPP_W-1:0] BPP_GRBW = 3'd4;
	localparam logic [BPP_W-1:0] BPP_RGB  = 3'd3;

	localparam logic [PCOUNT_W-1:0] PIXEL_COUNT_RESET = PCOUNT_W'(MAX_PIXELS);
	localparam logic [BIT_W-1:0]    BIT_LAST          = BIT_W'(BITS_PER_BYTE - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRITE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                en;
		logic [STORE_AW-1:0] addr;
		logic [LEVEL_W-1:0]  data;
	} store_wr_t;

endpackage

// ===== rtl/lsfe_store.sv =====
`timescale 1ns / 1ps

module lsfe_store import lsfe_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  store_wr_t           wr,
	input  logic                rd_en,
	input  logic [STORE_AW-1:0] rd_addr,
	output logic [LEVEL_W-1:0]  rd_data
);

	logic [LEVEL_W-1:0]     mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] written_q;
	logic [LEVEL_W-1:0]     rd_data_q;
	logic                   rd_written_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// One flag per entry stands in for clearing the array: an entry never
	// written since reset reads as zero, which is the LEDs-off level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr.en) begin
				written_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_written_q ? rd_data_q : '0;

endmodule

// ===== rtl/led_strip_frame_encoder.sv =====
`timescale 1ns / 1ps
`include "led_strip_frame_encoder_defines.svh"

// Channel   Handshake               Payload
// in        in_valid / in_ready     kind, pixel, red, green, blue, white, byte_pos
// out       out_valid / out_ready   buffer_index, duty, last
// cfg       cfg_write               cfg_index, cfg_data
//
// One item is in work at a time. set_pixel writes bytes_per_pixel store bytes and
// set_all writes bytes_per_pixel * pixel_count of them (none when pixel_count is zero), one store
// byte per cycle through the single write port. render_byte, if byte_pos is below the used byte
// count, reads the store as it is taken, then gives eight beats, one per cycle when out_ready stays high.
// Reset clears the store flags at once, so no clearing pass is needed.
// A stall on out holds the current beat and keeps in_ready low.

module led_strip_frame_encoder import lsfe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [KIND_W-1:0]     kind,
	input  logic [PIXEL_W-1:0]    pixel,
	input  logic [LEVEL_W-1:0]    red,
	input  logic [LEVEL_W-1:0]    green,
	input  logic [LEVEL_W-1:0]    blue,
	input  logic [LEVEL_W-1:0]    white,
	input  logic [POS_W-1:0]      byte_pos,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [INDEX_W-1:0]    buffer_index,
	output logic [DUTY_W-1:0]     duty,
	output logic                  last
);

	// Configuration registers.
	logic [PCOUNT_W-1:0] pixel_count_q;
	logic [BPP_W-1:0]    bpp_q;
	logic                slot_q;
	logic [DUTY_W-1:0]   duty_high_q;
	logic [DUTY_W-1:0]   duty_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= PIXEL_COUNT_RESET;
			bpp_q         <= BPP_GRBW;
			slot_q        <= 1'b1;
			duty_high_q   <= '0;
			duty_low_q    <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_PIXEL_COUNT:     pixel_count_q <= cfg_data[PCOUNT_W-1:0];
				CFG_BYTES_PER_PIXEL: bpp_q         <= cfg_data[BPP_W-1:0];
				CFG_CHANNEL_SLOT:    slot_q        <= cfg_data[0];
				CFG_DUTY_HIGH:       duty_high_q   <= cfg_data[DUTY_W-1:0];
				CFG_DUTY_LOW:        duty_low_q    <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective geometry. Any byte mode other than four acts as RGB.
	logic                eff_four;
	logic [PCOUNT_W-1:0] eff_pixels;
	logic [USED_W-1:0]   used;
	logic [USED_W-1:0]   pix_base;
	logic [USED_W-1:0]   bpp_n;
	logic [1:0]          sel_last;
	logic                render_hit;

	assign eff_four   = (bpp_q == BPP_GRBW);
	assign eff_pixels = (pixel_count_q > PIXEL_COUNT_RESET) ? PIXEL_COUNT_RESET : pixel_count_q;
	assign used       = eff_four ? (USED_W'(eff_pixels) << 2)
	                             : ((USED_W'(eff_pixels) << 1) + USED_W'(eff_pixels));
	assign pix_base   = eff_four ? (USED_W'(pixel) << 2)
	                             : ((USED_W'(pixel) << 1) + USED_W'(pixel));
	assign bpp_n      = eff_four ? USED_W'(BPP_GRBW) : USED_W'(BPP_RGB);
	assign sel_last   = eff_four ? 2'd3 : 2'd2;
	assign render_hit = (USED_W'(byte_pos) < used) && (USED_W'(byte_pos) < USED_W'(STORE_DEPTH));

	// Sequencer.
	state_t             state_q;
	state_t             state_d;
	logic               load_write;
	logic               step_write;
	logic               rd_en;
	logic               step_bit;

	logic [USED_W-1:0]  wr_addr_q;
	logic [USED_W-1:0]  left_q;
	logic [1:0]         sel_q;
	logic [LEVEL_W-1:0] red_q;
	logic [LEVEL_W-1:0] green_q;
	logic [LEVEL_W-1:0] blue_q;
	logic [LEVEL_W-1:0] white_q;
	logic [POS_W-1:0]   pos_q;
	logic [BIT_W-1:0]   bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		load_write = 1'b0;
		step_write = 1'b0;
		rd_en      = 1'b0;
		step_bit   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (kind)
						KIND_SET_PIXEL: begin
							load_write = 1'b1;
							state_d    = ST_WRITE;
						end
						KIND_SET_ALL: begin
							load_write = 1'b1;
							if (eff_pixels != '0) begin
								state_d = ST_WRITE;
							end
						end
						KIND_RENDER: begin
							if (render_hit) begin
								rd_en   = 1'b1;
								state_d = ST_EMIT;
							end
						end
						default: ;
					endcase
				end
			end
			ST_WRITE: begin
				step_write = 1'b1;
				if (left_q == USED_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					step_bit = 1'b1;
					if (bit_q == BIT_LAST) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_addr_q <= '0;
			left_q    <= '0;
			sel_q     <= '0;
			bit_q     <= '0;
		end else begin
			if (load_write) begin
				wr_addr_q <= (kind == KIND_SET_PIXEL) ? pix_base : '0;
				left_q    <= (kind == KIND_SET_PIXEL) ? bpp_n : used;
				sel_q     <= '0;
			end else if (step_write) begin
				wr_addr_q <= wr_addr_q + USED_W'(1);
				left_q    <= left_q - USED_W'(1);
				sel_q     <= (sel_q == sel_last) ? 2'd0 : sel_q + 2'd1;
			end
			if (rd_en) begin
				bit_q <= '0;
			end else if (step_bit) begin
				bit_q <= bit_q + BIT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_write) begin
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
			white_q <= white;
		end
		if (rd_en) begin
			pos_q <= byte_pos;
		end
	end

	// Byte order within a pixel is G,R,B,W in four-byte mode and R,G,B otherwise.
	logic [LEVEL_W-1:0] wr_byte;

	always_comb begin
		case (sel_q)
			2'd0:    wr_byte = eff_four ? green_q : red_q;
			2'd1:    wr_byte = eff_four ? red_q : green_q;
			2'd2:    wr_byte = blue_q;
			default: wr_byte = white_q;
		endcase
	end

	store_wr_t          store_wr;
	logic [LEVEL_W-1:0] rd_byte;

	assign store_wr.en   = step_write && (wr_addr_q < USED_W'(STORE_DEPTH));
	assign store_wr.addr = wr_addr_q[STORE_AW-1:0];
	assign store_wr.data = wr_byte;

	lsfe_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (store_wr),
		.rd_en   (rd_en),
		.rd_addr (byte_pos[STORE_AW-1:0]),
		.rd_data (rd_byte)
	);

	// Result beat, most significant bit first.
	logic [BIT_W-1:0]      bit_sel;
	logic [IDX_WIDE_W-1:0] idx_wide;

	assign bit_sel      = BIT_LAST - bit_q;
	assign idx_wide     = IDX_WIDE_W'({pos_q, bit_q}) * IDX_WIDE_W'(CHANNEL_COUNT)
	                      + IDX_WIDE_W'(slot_q);
	assign buffer_index = idx_wide[INDEX_W-1:0];
	assign duty         = rd_byte[bit_sel] ? duty_high_q : duty_low_q;
	assign last         = (bit_q == BIT_LAST);

	`ASSERT_IMPLIES(a_no_input_while_emitting, clk, arst_n, out_valid, !in_ready)
	`ASSERT_NEXT(a_idle_after_last_beat, clk, arst_n, out_valid && out_ready && last, in_ready)
	`ASSERT_NEXT(a_render_starts_emit, clk, arst_n, rd_en, out_valid && (bit_q == '0))
	`ASSERT_IMPLIES(a_no_store_write_while_emitting, clk, arst_n, store_wr.en, !out_valid && !in_ready)

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import lsfe_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	// A set_all walks at most 64 store bytes, so this covers any write still in flight.
	localparam int SETTLE_CYCLES = 90;
	localparam int CYCLE_LIMIT   = 500_000;
	localparam int NUM_ROWS      = 28;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [PIXEL_W-1:0] pixel;
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
		logic [LEVEL_W-1:0] white;
		logic [POS_W-1:0]   pos;
	} led_cmd_t;

	localparam int CMD_W = $bits(led_cmd_t);

	typedef struct packed {
		logic [2:0]         phase;
		logic               fixed;
		logic [LEVEL_W-1:0] fixed_byte;
		logic [KIND_W-1:0]  kind;
		logic [PIXEL_W-1:0] pixel;
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
		logic [LEVEL_W-1:0] white;
		logic [POS_W-1:0]   pos;
	} dir_row_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] pixels;
		logic [CFG_DATA_W-1:0] bpp;
		logic [CFG_DATA_W-1:0] slot;
		logic [CFG_DATA_W-1:0] high;
		logic [CFG_DATA_W-1:0] low;
	} cfg_set_t;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic [DUTY_W-1:0]  duty;
		logic               last;
	} duty_beat_t;

	// Phase 0 is the state after reset and is never written.
	localparam cfg_set_t PHASE_CFG [5] = '{
		'{16'd16, 16'd4, 16'd1, 16'h0000, 16'h0000},
		'{16'd16, 16'd4, 16'd1, 16'hFFFF, 16'h0000},
		'{16'd1,  16'd3, 16'd0, 16'h1234, 16'hFFFF},
		'{16'd0,  16'd7, 16'd1, 16'hAAAA, 16'h5555},
		'{16'd31, 16'd0, 16'd0, 16'h0F0F, 16'hF0F0}
	};

	localparam dir_row_t DIRECTED [NUM_ROWS] = '{
		'{3'd0, 1'b1, 8'h00, KIND_RENDER,    4'd0,  8'h00, 8'h00, 8'h00, 8'h00, 6'd0},
		'{3'd0, 1'b1, 8'h00, KIND_RENDER,    4'd0,  8'h00, 8'h00, 8'h00, 8'h00, 6'd63},
		'{3'd1, 1'b0, 8'h00, KIND_SET_PIXEL, 4'd0,  8'hFF, 8'h00, 8'hFF, 8'h00, 6'd0},
		'{3'd1, 1'b1, 8'h00, KIND_RENDER,    4'd0,  8'h00, 8'h00, 8'h00, 8'h00, 6'd0},
		'{3'd1, 1'b1, 8'hFF, KIND_RENDER,    4'd0,  8'h00, 8'h00, 8'h00, 8'h00, 6'd1},
		'{3'd1, 1'b1, 8'h00, KIND_RENDER,    4'd0,  8'h00, 8'h00, 8'h00, 8'h00, 6'd3},
		'{3'd1, 1'b0, 8'h00, KIND_SET_PIXEL, 4'd15, 8'h12, 8'h34, 8'h56, 8'h78, 6'd63},
		'{3'd1, 1'b1, 8'h78, KIND_RENDER,    4'd0,  8'h00, 8'h00, 8'h00, 8'h00, 6'd63},
		'{3'd1, 1'b1, 8'h34, KIND_RENDER,    4'd0,  8'h00, 8'h00, 8'h00, 8'h00, 6'd60},
		'{3'd1, 1'b0, 8'h00, KIND_SET_ALL,   4'd0,  8'hA5, 8'h5A, 8'hC3, 8'h3C, 6'd0},
		'{3'd1, 1'b1, 8'hC3, KIND_RENDER,    4'd0,  8'h00, 8'h00, 8'h00, 8'h00, 6'd62},
		'{3'd1, 1'b0, 8'h00, KIND_UNUSED,    4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'd0},
		'{3'd1, 1'b1, 8'h5A, KIND_RENDER,    4'd0,  8'h00, 8'h00, 8'h00, 8'h00, 6'd0},
		'{3'd2, 1'b0, 8'h00, KIND_SET_PIXEL, 4'd0,  8'h80, 8'h01, 8'hFE, 8'hFF, 6'd0},
		'{3'd2, 1'b1, 8'hFE, KIND_RENDER,    4'd0,  8'h00, 8'h00, 8'h00, 8'h00, 6'd2},
		'{3'd2, 1'b1, 8'h80, KIND_RENDER,    4'd0,  8'h00, 8'h00, 8'h00, 8'h00, 6'd0},
		'{3'd2, 1'b0, 8'h00, KIND_RENDER,    4'd0,  8'h00, 8'h00, 8'h00, 8'h00, 6'd3},
		'{3'd2, 1'b0, 8'h00, KIND_SET_PIXEL, 4'd7,  8'h11, 8'h22, 8'h33, 8'h44, 6'd0},
		'{3'd2, 1'b0, 8'h00, KIND_RENDER,    4'd0,  8'h00, 8'h00, 8'h00, 8'h00, 6'd21},
		'{3'd2, 1'b0, 8'h00, KIND_SET_ALL,   4'd0,  8'h00, 8'hFF, 8'h00, 8'hFF, 6'd0},
		'{3'd2, 1'b1, 8'hFF, KIND_RENDER,    4'd0,  8'h00, 8'h00, 8'h00, 8'h00, 6'd1},
		'{3'd3, 1'b0, 8'h00, KIND_SET_ALL,   4'd0,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'd0},
		'{3'd3, 1'b0, 8'h00, KIND_RENDER,    4'd0,  8'h00, 8'h00, 8'h00, 8'h00, 6'd0},
		'{3'd3, 1'b0, 8'h00, KIND_SET_PIXEL, 4'd2,  8'h0F, 8'hF0, 8'h3C, 8'hC3, 6'd0},
		'{3'd4, 1'b1, 8'hF0, KIND_RENDER,    4'd0,  8'h00, 8'h00, 8'h00, 8'h00, 6'd7},
		'{3'd4, 1'b1, 8'h3C, KIND_RENDER,    4'd0,  8'h00, 8'h00, 8'h00, 8'h00, 6'd47},
		'{3'd4, 1'b0, 8'h00, KIND_RENDER,    4'd0,  8'h00, 8'h00, 8'h00, 8'h00, 6'd48},
		'{3'd4, 1'b0, 8'h00, KIND_SET_PIXEL, 4'd15, 8'h01, 8'h02, 8'h03, 8'h04, 6'd47}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [KIND_W-1:0]     kind = '0;
	logic [PIXEL_W-1:0]    pixel = '0;
	logic [LEVEL_W-1:0]    red = '0;
	logic [LEVEL_W-1:0]    green = '0;
	logic [LEVEL_W-1:0]    blue = '0;
	logic [LEVEL_W-1:0]    white = '0;
	logic [POS_W-1:0]      byte_pos = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [INDEX_W-1:0]    buffer_index;
	logic [DUTY_W-1:0]     duty;
	logic                  last;

	// Shadow of the strip state and registers.
	logic [LEVEL_W-1:0]  colour_mem [STORE_DEPTH];
	logic [PCOUNT_W-1:0] pixel_reg = PIXEL_COUNT_RESET;
	logic [BPP_W-1:0]    bpp_reg = BPP_GRBW;
	logic                slot_reg = 1'b1;
	logic [DUTY_W-1:0]   duty_one = '0;
	logic [DUTY_W-1:0]   duty_zero = '0;

	duty_beat_t  duty_beats_due [$];
	duty_beat_t  head;
	int unsigned src_idle = 30;
	int unsigned sink_idle = 72;
	int unsigned errors = 0;
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	int unsigned beats_seen = 0;
	int unsigned settings_used = 0;

	led_strip_frame_encoder u_dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < STORE_DEPTH; i++) colour_mem[i] = '0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
				duty_beats_due.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int unsigned bpp_eff();
		return (bpp_reg == BPP_GRBW) ? 4 : 3;
	endfunction

	function automatic int unsigned pixels_eff();
		return (pixel_reg > MAX_PIXELS) ? MAX_PIXELS : int'(pixel_reg);
	endfunction

	function automatic void put_byte(int unsigned pos, logic [LEVEL_W-1:0] val);
		if (pos < STORE_DEPTH) colour_mem[pos] = val;
	endfunction

	function automatic void store_pixel(int unsigned idx, led_cmd_t c);
		int unsigned base;
		base = bpp_eff() * idx;
		if (bpp_eff() == 4) begin
			put_byte(base, c.green);
			put_byte(base + 1, c.red);
			put_byte(base + 2, c.blue);
			put_byte(base + 3, c.white);
		end else begin
			put_byte(base, c.red);
			put_byte(base + 1, c.green);
			put_byte(base + 2, c.blue);
		end
	endfunction

	// Applies one accepted item to the shadow store and queues the duty beats it renders.
	// With use_fixed set, the rendered byte is the one typed into the table.
	function automatic void encode_cmd(led_cmd_t c, bit use_fixed, logic [LEVEL_W-1:0] fixed_byte);
		int unsigned used;
		logic [LEVEL_W-1:0] val;
		duty_beat_t b;
		used = bpp_eff() * pixels_eff();
		case (c.kind)
			KIND_SET_PIXEL: store_pixel(c.pixel, c);
			KIND_SET_ALL: begin
				for (int p = 0; p < pixels_eff(); p++) store_pixel(p, c);
			end
			KIND_RENDER: begin
				if (c.pos < used) begin
					val = use_fixed ? fixed_byte : colour_mem[c.pos];
					for (int i = 0; i < BITS_PER_BYTE; i++) begin
						b.index = INDEX_W'((BITS_PER_BYTE * int'(c.pos) + i) * CHANNEL_COUNT
							+ int'(slot_reg));
						b.duty = val[BITS_PER_BYTE-1-i] ? duty_one : duty_zero;
						b.last = (i == BITS_PER_BYTE - 1);
						duty_beats_due.push_back(b);
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_PIXEL_COUNT:     pixel_reg = data[PCOUNT_W-1:0];
			CFG_BYTES_PER_PIXEL: bpp_reg = data[BPP_W-1:0];
			CFG_CHANNEL_SLOT:    slot_reg = data[0];
			CFG_DUTY_HIGH:       duty_one = data;
			CFG_DUTY_LOW:        duty_zero = data;
			default: ;
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		apply_reg(idx, data);
	endtask

	task automatic program_regs(input cfg_set_t s);
		write_reg(CFG_PIXEL_COUNT, s.pixels);
		write_reg(CFG_BYTES_PER_PIXEL, s.bpp);
		write_reg(CFG_CHANNEL_SLOT, s.slot);
		write_reg(CFG_DUTY_HIGH, s.high);
		write_reg(CFG_DUTY_LOW, s.low);
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	// Valid is dropped here only when a gap is taken, so back-to-back items keep it high.
	task automatic send_cmd(input led_cmd_t c, input bit use_fixed,
			input logic [LEVEL_W-1:0] fixed_byte);
		if ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle);
		end
		in_valid <= 1'b1;
		kind <= c.kind;
		pixel <= c.pixel;
		red <= c.red;
		green <= c.green;
		blue <= c.blue;
		white <= c.white;
		byte_pos <= c.pos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		encode_cmd(c, use_fixed, fixed_byte);
		items_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (duty_beats_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int unsigned items);
		int unsigned done;
		int unsigned seg_len;
		int unsigned used;
		int unsigned roll;
		cfg_set_t s;
		led_cmd_t c;
		done = 0;
		while (done < items) begin
			settle();
			s.pixels = CFG_DATA_W'($urandom());
			roll = $urandom_range(99);
			if (roll < 6) s.pixels[PCOUNT_W-1:0] = '0;
			else if (roll < 14) s.pixels[PCOUNT_W-1:0] = PCOUNT_W'($urandom_range(31, 17));
			else if (roll < 24) s.pixels[PCOUNT_W-1:0] = PCOUNT_W'(1);
			else if (roll < 34) s.pixels[PCOUNT_W-1:0] = PCOUNT_W'(MAX_PIXELS);
			else s.pixels[PCOUNT_W-1:0] = PCOUNT_W'($urandom_range(MAX_PIXELS, 1));
			s.bpp = CFG_DATA_W'($urandom());
			if ($urandom_range(99) < 80) s.bpp[BPP_W-1:0] = $urandom_range(1) ? BPP_GRBW : BPP_RGB;
			s.slot = CFG_DATA_W'($urandom());
			roll = $urandom_range(99);
			s.high = (roll < 15) ? 16'h0000 : (roll < 30) ? 16'hFFFF : 16'($urandom());
			roll = $urandom_range(99);
			s.low = (roll < 15) ? 16'h0000 : (roll < 30) ? 16'hFFFF : 16'($urandom());
			program_regs(s);
			used = bpp_eff() * pixels_eff();
			seg_len = $urandom_range(35, 15);
			for (int n = 0; n < seg_len && done < items; n++) begin
				c = led_cmd_t'(CMD_W'({$urandom(), $urandom()}));
				roll = $urandom_range(99);
				if (roll < 48) begin
					c.kind = KIND_RENDER;
					if (used > 0 && $urandom_range(99) < 90)
						c.pos = POS_W'($urandom_range(used - 1));
				end else if (roll < 82) begin
					c.kind = KIND_SET_PIXEL;
				end else if (roll < 93) begin
					c.kind = KIND_SET_ALL;
				end else begin
					c.kind = KIND_UNUSED;
				end
				send_cmd(c, 1'b0, '0);
				done++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			beats_seen++;
			if (duty_beats_due.size() == 0) begin
				$error("unexpected beat: buffer_index %0d, duty %h, last %b",
					buffer_index, duty, last);
				errors++;
			end else begin
				head = duty_beats_due.pop_front();
				if (buffer_index !== head.index) begin
					$error("buffer_index: expected %0d, got %0d", head.index, buffer_index);
					errors++;
				end
				if (duty !== head.duty) begin
					$error("duty: expected %h, got %h", head.duty, duty);
					errors++;
				end
				if (last !== head.last) begin
					$error("last: expected %b, got %b", head.last, last);
					errors++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= sink_idle);
	end

	initial begin
		int unsigned phase_now;
		led_cmd_t c;
		phase_now = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NUM_ROWS; r++) begin
			if (DIRECTED[r].phase != phase_now) begin
				settle();
				phase_now = DIRECTED[r].phase;
				program_regs(PHASE_CFG[phase_now]);
			end
			c.kind = DIRECTED[r].kind;
			c.pixel = DIRECTED[r].pixel;
			c.red = DIRECTED[r].red;
			c.green = DIRECTED[r].green;
			c.blue = DIRECTED[r].blue;
			c.white = DIRECTED[r].white;
			c.pos = DIRECTED[r].pos;
			send_cmd(c, DIRECTED[r].fixed, DIRECTED[r].fixed_byte);
		end

		run_random(148);
		src_idle = 72;
		sink_idle = 30;
		run_random(148);
		src_idle = 0;
		sink_idle = 0;
		run_random(146);
		settle();

		$display("Sent %0d items and checked %0d duty beats under %0d register settings,",
			items_sent, beats_seen, settings_used);
		$display("with sender and receiver stalls swapped between runs and then removed.");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
